// ===== sv/kmms_pkg.sv =====
// Shared constants, codes and types of the k-way merge selector.
package kmms_pkg;

    localparam int LANES_DEF     = 16;
    localparam int KEY_WORDS_DEF = 8;
    localparam int TAG_BITS_DEF  = 32;

    localparam int WORD_BITS   = 64;
    localparam int DIGIT_BITS  = 8;
    localparam int DIGITS      = WORD_BITS / DIGIT_BITS;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_EXHAUST = 2'd1;
    localparam logic [1:0] OP_POP     = 2'd2;

    localparam logic [1:0] ST_SELECTED  = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_WAITING   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_RD,
        S_LD,
        S_SH,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } cmp_ctrl_t;

    typedef struct packed {
        logic decided;
        logic less;
    } cmp_stat_t;

endpackage

// ===== sv/kway_merge_min_select.sv =====
// Top level of the k-way merge selector: lane state, sequencer and result register.
//
// Commands are taken when start is high and busy is low. A key word write or an
// exhaust leaves busy low. A pop that answers exhausted or waiting also leaves
// busy low and returns its result on the next cycle. A pop that selects walks
// the lanes one per cycle while no comparison runs, takes the first active lane
// as the initial best and compares each later active lane against the current
// best through a digit-serial comparator, one key byte per cycle, reading both
// key words from the key store: each compared word passes through read, load,
// 8 byte steps and evaluate, and a lane stops at the first differing word. The
// result appears for one cycle on result_strobe and cannot be held off by the
// receiver; the next command may be issued in that same cycle. The
// configuration channel is ready while no selecting pop is running.
module kway_merge_min_select
    import kmms_pkg::*;
#(
    parameter int LANES     = LANES_DEF,
    parameter int KEY_WORDS = KEY_WORDS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [3:0]  lane,
    input  logic [2:0]  word_index,
    input  logic [63:0] key_word,
    input  logic [31:0] record_tag,
    input  logic        last_word,
    output logic        result_strobe,
    output logic [1:0]  status,
    output logic [3:0]  chosen_lane,
    output logic [31:0] chosen_tag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int LANE_W = $clog2(LANES);
    localparam int WORD_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int DEPTH  = LANES * KEY_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [LANE_W-1:0]      LAST_LANE  = LANE_W'(LANES - 1);
    localparam logic [WORD_W-1:0]      LAST_WORD  = WORD_W'(KEY_WORDS - 1);
    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(DIGITS - 1);

    state_t                  state_reg, state_next;
    logic [LANE_W-1:0]       cand_reg, cand_next;
    logic [LANE_W-1:0]       best_reg, best_next;
    logic                    have_best_reg, have_best_next;
    logic [WORD_W-1:0]       word_reg, word_next;
    logic [DIGIT_CNT_W-1:0]  digit_reg, digit_next;
    logic [LANES-1:0]        lane_valid_reg, lane_valid_next;
    logic [LANES-1:0]        lane_exh_reg, lane_exh_next;
    logic [4:0]              lanes_in_use_reg, lanes_in_use_next;
    logic                    strobe_reg, strobe_next;
    logic [1:0]              status_reg, status_next;
    logic [3:0]              lane_out_reg, lane_out_next;
    logic [31:0]             tag_out_reg, tag_out_next;
    logic [TAG_BITS-1:0]     tag_store_reg [LANES];

    logic                    accept;
    logic                    lane_ok;
    logic                    word_ok;
    logic [LANE_W-1:0]       lane_idx;
    logic [WORD_W-1:0]       word_idx;
    logic [LANES-1:0]        active;
    logic                    pending;
    logic                    key_we;
    logic                    tag_we;
    logic [ADDR_W-1:0]       waddr;
    logic [ADDR_W-1:0]       raddr_a;
    logic [ADDR_W-1:0]       raddr_b;
    logic [WORD_BITS-1:0]    rdata_a;
    logic [WORD_BITS-1:0]    rdata_b;
    cmp_ctrl_t               cmp_ctrl;
    cmp_stat_t               cmp_stat;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    // hold off lane count changes while a selecting pop is running
    assign cfg_ready = !busy;
    assign lane_ok   = (int'(lane) < LANES);
    assign word_ok   = (int'(word_index) < KEY_WORDS);
    assign lane_idx  = LANE_W'(lane);
    assign word_idx  = WORD_W'(word_index);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            active[l] = (l < int'(lanes_in_use_reg)) && !lane_exh_reg[l];
        end
    end

    assign pending = |(active & ~lane_valid_reg);

    assign waddr   = ADDR_W'(int'(lane_idx) * KEY_WORDS + int'(word_idx));
    assign raddr_a = ADDR_W'(int'(cand_reg) * KEY_WORDS + int'(word_reg));
    assign raddr_b = ADDR_W'(int'(best_reg) * KEY_WORDS + int'(word_reg));

    kmms_key_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .clk     (clk),
        .we      (key_we),
        .waddr   (waddr),
        .wdata   (key_word),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    kmms_digit_cmp u_cmp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cmp_ctrl),
        .word_a (rdata_a),
        .word_b (rdata_b),
        .stat   (cmp_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_POP) && (|active) && !pending)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (active[cand_reg] && have_best_reg)
                begin
                    state_next = S_RD;
                end
                else if (cand_reg == LAST_LANE)
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                state_next = S_SH;
            end
            S_SH:
            begin
                if (digit_reg == LAST_DIGIT)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (cmp_stat.decided || (word_reg == LAST_WORD))
                begin
                    state_next = (cand_reg == LAST_LANE) ? S_DONE : S_FIND;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cand_next         = cand_reg;
        best_next         = best_reg;
        have_best_next    = have_best_reg;
        word_next         = word_reg;
        digit_next        = digit_reg;
        lane_valid_next   = lane_valid_reg;
        lane_exh_next     = lane_exh_reg;
        lanes_in_use_next = lanes_in_use_reg;
        strobe_next       = 1'b0;
        status_next       = status_reg;
        lane_out_next     = lane_out_reg;
        tag_out_next      = tag_out_reg;
        key_we            = 1'b0;
        tag_we            = 1'b0;
        cmp_ctrl          = '0;

        if (cfg_valid && cfg_ready)
        begin
            lanes_in_use_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_WRITE:
                        begin
                            if (lane_ok && word_ok && !lane_exh_reg[lane_idx])
                            begin
                                key_we                    = 1'b1;
                                tag_we                    = 1'b1;
                                lane_valid_next[lane_idx] = last_word;
                            end
                        end
                        OP_EXHAUST:
                        begin
                            if (lane_ok)
                            begin
                                lane_exh_next[lane_idx]   = 1'b1;
                                lane_valid_next[lane_idx] = 1'b0;
                            end
                        end
                        OP_POP:
                        begin
                            if (!(|active))
                            begin
                                strobe_next   = 1'b1;
                                status_next   = ST_EXHAUSTED;
                                lane_out_next = '0;
                                tag_out_next  = '0;
                            end
                            else if (pending)
                            begin
                                strobe_next   = 1'b1;
                                status_next   = ST_WAITING;
                                lane_out_next = '0;
                                tag_out_next  = '0;
                            end
                            else
                            begin
                                cand_next      = '0;
                                have_best_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (active[cand_reg] && have_best_reg)
                begin
                    word_next = '0;
                end
                else
                begin
                    // first active lane becomes the initial best
                    if (active[cand_reg])
                    begin
                        best_next      = cand_reg;
                        have_best_next = 1'b1;
                    end
                    if (cand_reg != LAST_LANE)
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
            end
            S_RD:
            begin
            end
            S_LD:
            begin
                cmp_ctrl.load  = 1'b1;
                cmp_ctrl.clear = (word_reg == '0);
                digit_next     = '0;
            end
            S_SH:
            begin
                cmp_ctrl.shift = 1'b1;
                digit_next     = digit_reg + 1'b1;
            end
            S_EVAL:
            begin
                if (cmp_stat.decided || (word_reg == LAST_WORD))
                begin
                    // strictly smaller only: ties keep the lower lane
                    if (cmp_stat.decided && cmp_stat.less)
                    begin
                        best_next = cand_reg;
                    end
                    if (cand_reg != LAST_LANE)
                    begin
                        cand_next = cand_reg + 1'b1;
                    end
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                strobe_next               = 1'b1;
                status_next               = ST_SELECTED;
                lane_out_next             = 4'(best_reg);
                tag_out_next              = 32'(tag_store_reg[best_reg]);
                lane_valid_next[best_reg] = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cand_reg         <= '0;
            best_reg         <= '0;
            have_best_reg    <= 1'b0;
            word_reg         <= '0;
            digit_reg        <= '0;
            lane_valid_reg   <= '0;
            lane_exh_reg     <= '0;
            lanes_in_use_reg <= 5'd16;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cand_reg         <= cand_next;
            best_reg         <= best_next;
            have_best_reg    <= have_best_next;
            word_reg         <= word_next;
            digit_reg        <= digit_next;
            lane_valid_reg   <= lane_valid_next;
            lane_exh_reg     <= lane_exh_next;
            lanes_in_use_reg <= lanes_in_use_next;
            strobe_reg       <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        lane_out_reg <= lane_out_next;
        tag_out_reg  <= tag_out_next;
        if (tag_we)
        begin
            tag_store_reg[lane_idx] <= TAG_BITS'(record_tag);
        end
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign chosen_lane   = lane_out_reg;
    assign chosen_tag    = tag_out_reg;

    a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> !busy)
        else $error("result strobe while a pop is still running");

    a_no_valid_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid_reg & lane_exh_reg) == '0)
        else $error("lane both valid and exhausted");

    a_scan_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ((active & ~lane_valid_reg) == '0))
        else $error("active lane empty during a selecting pop");

    a_chosen_was_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (status == ST_SELECTED)) |-> $past(lane_valid_reg[best_reg]))
        else $error("selected lane held no valid head");

endmodule

// ===== sv/kmms_key_mem.sv =====
// Head key store: one write port, two registered read ports.
module kmms_key_mem
    import kmms_pkg::*;
#(
    parameter int DEPTH  = LANES_DEF * KEY_WORDS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]    raddr_a,
    input  logic [ADDR_W-1:0]    raddr_b,
    output logic [WORD_BITS-1:0] rdata_a,
    output logic [WORD_BITS-1:0] rdata_b
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_a_reg;
    logic [WORD_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== sv/kmms_digit_cmp.sv =====
// Digit-serial unsigned comparator with a sticky decision across key words.
module kmms_digit_cmp
    import kmms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmp_ctrl_t            ctrl,
    input  logic [WORD_BITS-1:0] word_a,
    input  logic [WORD_BITS-1:0] word_b,
    output cmp_stat_t            stat
);

    logic [WORD_BITS-1:0]  a_sh_reg, a_sh_next;
    logic [WORD_BITS-1:0]  b_sh_reg, b_sh_next;
    logic                  decided_reg, decided_next;
    logic                  less_reg, less_next;
    logic [DIGIT_BITS-1:0] a_dig;
    logic [DIGIT_BITS-1:0] b_dig;

    assign a_dig = a_sh_reg[WORD_BITS-1 -: DIGIT_BITS];
    assign b_dig = b_sh_reg[WORD_BITS-1 -: DIGIT_BITS];

    always_comb
    begin
        a_sh_next    = a_sh_reg;
        b_sh_next    = b_sh_reg;
        decided_next = decided_reg;
        less_next    = less_reg;
        if (ctrl.clear)
        begin
            decided_next = 1'b0;
            less_next    = 1'b0;
        end
        if (ctrl.load)
        begin
            a_sh_next = word_a;
            b_sh_next = word_b;
        end
        else if (ctrl.shift)
        begin
            // first differing digit, most significant first, settles the order
            if (!decided_reg && (a_dig != b_dig))
            begin
                decided_next = 1'b1;
                less_next    = (a_dig < b_dig);
            end
            a_sh_next = {a_sh_reg[WORD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
            b_sh_next = {b_sh_reg[WORD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decided_reg <= 1'b0;
            less_reg    <= 1'b0;
        end
        else
        begin
            decided_reg <= decided_next;
            less_reg    <= less_next;
        end
    end

    assign stat.decided = decided_reg;
    assign stat.less    = less_reg;

endmodule
